// ----- hw/rtl/dpat_pkg.sv -----
// dpat_pkg: shared types and constants for the demand paged address translator
// used by dpat_ctrl, dpat_datapath and demand_paged_address_translator
// no dependencies
package dpat_pkg;

    localparam int PAGE_BYTES       = 256;
    localparam int PAGE_BITS        = 8;
    localparam int FIRST_DATA_FRAME = 2;

    localparam logic [1:0] MODE_XLATE     = 2'd0;
    localparam logic [1:0] MODE_LOAD_MAIN = 2'd1;
    localparam logic [1:0] MODE_LOAD_DISK = 2'd2;
    localparam logic [1:0] MODE_NOP       = 2'd3;

    localparam logic [7:0] FREE_MARK   = 8'h20;
    localparam logic [7:0] PRESENT_SET = 8'h01;
    localparam logic [7:0] PT_PRESENT_PAGE = 8'h01;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_PFN,
        S_RD_PRES,
        S_CHECK,
        S_RD_DATA,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_COPY,
        S_PT_WR,
        S_PR_WR,
        S_LOAD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic rd_pfn;
        logic rd_pres;
        logic latch_pfn;
        logic set_fault;
        logic rd_data;
        logic scan_init;
        logic scan_rd;
        logic scan_next;
        logic scan_fallback;
        logic copy_init;
        logic copy_step;
        logic pt_wr;
        logic pr_wr;
        logic load_wr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_xlate;
        logic present;
        logic free_hit;
        logic scan_last;
        logic copy_done;
        logic out_free;
    } t_dp_status;

endpackage

// ----- hw/rtl/dpat_datapath.sv -----
// dpat_datapath: main and disk memories, address and result registers
// depends on dpat_pkg; driven by dpat_ctrl through t_dp_cmd
module dpat_datapath
    import dpat_pkg::*;
#(
    parameter int MAIN_BYTES = 65536,
    parameter int DISK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic        o_fault,
    output logic [7:0]  o_frame,
    output logic [15:0] o_phys_address,
    output logic [7:0]  o_data
);

    localparam int MAW        = $clog2(MAIN_BYTES);
    localparam int DAW        = $clog2(DISK_BYTES);
    localparam int FW         = MAW - PAGE_BITS;
    localparam int NUM_FRAMES = MAIN_BYTES / PAGE_BYTES;

    logic [7:0] r_main_mem [MAIN_BYTES];
    logic [7:0] r_disk_mem [DISK_BYTES];

    logic [1:0]    r_mode;
    logic [15:0]   r_addr;
    logic [7:0]    r_wdata;
    logic [7:0]    r_pfn;
    logic          r_fault;
    logic [FW-1:0] r_frame;
    logic [8:0]    r_idx;
    logic [7:0]    r_main_q;
    logic [7:0]    r_disk_q;

    logic          r_out_valid;
    logic          r_out_fault;
    logic [7:0]    r_out_frame;
    logic [15:0]   r_out_phys;
    logic [7:0]    r_out_data;

    logic [15:0]   main_addr;
    logic [7:0]    main_wdata;
    logic          main_we;
    logic          main_re;
    logic          copy_wr;
    logic [7:0]    idx_prev;
    logic [15:0]   disk_full;
    logic [15:0]   disk_addr;
    logic          disk_we;
    logic          disk_re;
    logic          res_xlate;
    logic          res_hit;

    assign idx_prev = 8'(r_idx - 9'd1);
    assign copy_wr  = i_cmd.copy_step && (r_idx != 9'd0);
    assign main_re  = i_cmd.rd_pfn || i_cmd.rd_pres || i_cmd.rd_data || i_cmd.scan_rd;
    assign main_we  = copy_wr || i_cmd.pt_wr || i_cmd.pr_wr
                   || (i_cmd.load_wr && (r_mode == MODE_LOAD_MAIN));

    always_comb begin
        main_addr  = r_addr;
        main_wdata = r_wdata;
        if (i_cmd.rd_pfn || i_cmd.pt_wr) begin
            main_addr  = {8'h00, r_addr[15:8]};
            main_wdata = 8'(r_frame);
        end else if (i_cmd.rd_pres || i_cmd.pr_wr) begin
            main_addr  = {PT_PRESENT_PAGE, r_addr[15:8]};
            main_wdata = PRESENT_SET;
        end else if (i_cmd.rd_data) begin
            main_addr = {r_pfn, r_addr[7:0]};
        end else if (i_cmd.scan_rd) begin
            main_addr = {8'(r_frame), 8'h00};
        end else if (copy_wr) begin
            main_addr  = {8'(r_frame), idx_prev};
            main_wdata = r_disk_q;
        end
    end

    assign disk_full = {r_pfn, r_idx[7:0]};
    assign disk_re   = i_cmd.copy_step && !r_idx[8];
    assign disk_we   = i_cmd.load_wr && (r_mode == MODE_LOAD_DISK);
    assign disk_addr = disk_we ? r_addr : disk_full;

    always_ff @(posedge i_clk) begin
        if (main_we) begin
            r_main_mem[main_addr[MAW-1:0]] <= main_wdata;
        end
        if (main_re) begin
            r_main_q <= r_main_mem[main_addr[MAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (disk_we) begin
            r_disk_mem[disk_addr[DAW-1:0]] <= r_wdata;
        end
        if (disk_re) begin
            r_disk_q <= r_disk_mem[disk_addr[DAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
            r_fault <= 1'b0;
        end else if (i_cmd.set_fault) begin
            r_fault <= 1'b1;
        end
        if (i_cmd.latch_pfn) begin
            r_pfn <= r_main_q;
        end
        if (i_cmd.scan_init || i_cmd.scan_fallback) begin
            r_frame <= FW'(FIRST_DATA_FRAME);
        end else if (i_cmd.scan_next) begin
            r_frame <= r_frame + FW'(1);
        end
        if (i_cmd.copy_init) begin
            r_idx <= 9'd0;
        end else if (i_cmd.copy_step) begin
            r_idx <= r_idx + 9'd1;
        end
    end

    assign res_xlate = (r_mode == MODE_XLATE);
    assign res_hit   = res_xlate && !r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_fault <= res_xlate && r_fault;
            r_out_frame <= res_xlate ? r_pfn : 8'h00;
            r_out_phys  <= res_hit ? {r_pfn, r_addr[7:0]} : 16'h0000;
            r_out_data  <= res_hit ? r_main_q : 8'h00;
        end
    end

    assign o_status.in_xlate  = (i_mode == MODE_XLATE);
    assign o_status.present   = (r_main_q != 8'h00);
    assign o_status.free_hit  = (r_main_q == FREE_MARK);
    assign o_status.scan_last = (r_frame == FW'(NUM_FRAMES - 1));
    assign o_status.copy_done = r_idx[8];
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_fault        = r_out_fault;
    assign o_frame        = r_out_frame;
    assign o_phys_address = r_out_phys;
    assign o_data         = r_out_data;

endmodule

// ----- hw/rtl/dpat_ctrl.sv -----
// dpat_ctrl: sequencer for lookup, free frame scan, page copy and loads
// depends on dpat_pkg; commands dpat_datapath
module dpat_ctrl
    import dpat_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.in_xlate ? S_RD_PFN : S_LOAD;
                end
            end
            S_RD_PFN:  n_state = S_RD_PRES;
            S_RD_PRES: n_state = S_CHECK;
            S_CHECK:   n_state = i_status.present ? S_RD_DATA : S_SCAN_RD;
            S_RD_DATA: n_state = S_DONE;
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_status.free_hit || i_status.scan_last) begin
                    n_state = S_COPY;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_COPY: begin
                if (i_status.copy_done) begin
                    n_state = S_PT_WR;
                end
            end
            S_PT_WR: n_state = S_PR_WR;
            S_PR_WR: n_state = S_DONE;
            S_LOAD:  n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_RD_PFN:  o_cmd.rd_pfn = 1'b1;
            S_RD_PRES: begin
                o_cmd.rd_pres   = 1'b1;
                o_cmd.latch_pfn = 1'b1;
            end
            S_CHECK: begin
                o_cmd.set_fault = !i_status.present;
                o_cmd.scan_init = !i_status.present;
            end
            S_RD_DATA: o_cmd.rd_data = 1'b1;
            S_SCAN_RD: o_cmd.scan_rd = 1'b1;
            S_SCAN_CHK: begin
                if (i_status.free_hit) begin
                    o_cmd.copy_init = 1'b1;
                end else if (i_status.scan_last) begin
                    o_cmd.scan_fallback = 1'b1;
                    o_cmd.copy_init     = 1'b1;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_COPY:  o_cmd.copy_step = 1'b1;
            S_PT_WR: o_cmd.pt_wr = 1'b1;
            S_PR_WR: o_cmd.pr_wr = 1'b1;
            S_LOAD:  o_cmd.load_wr = 1'b1;
            S_DONE:  o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- hw/rtl/demand_paged_address_translator.sv -----
// demand_paged_address_translator: one transaction in flight at a time
// translation hit: states RD_PFN, RD_PRES, CHECK and RD_DATA, then DONE loads the result
// load and no-op: state LOAD writes main or disk (a no-op writes nothing), then DONE loads the result
// page fault: CHECK, then SCAN_RD and SCAN_CHK per frame scanned, COPY, PT_WR, PR_WR and DONE
// (one main memory read per scanned frame, the page copy runs in COPY); an output stall holds DONE
// reset clears the sequencer and output valid only, memory contents stay undefined until written
module demand_paged_address_translator
    import dpat_pkg::*;
#(
    parameter int MAIN_BYTES = 65536,
    parameter int DISK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_fault,
    output logic [7:0]  o_frame,
    output logic [15:0] o_phys_address,
    output logic [7:0]  o_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    dpat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dpat_datapath #(
        .MAIN_BYTES (MAIN_BYTES),
        .DISK_BYTES (DISK_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_mode         (i_mode),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_fault        (o_fault),
        .o_frame        (o_frame),
        .o_phys_address (o_phys_address),
        .o_data         (o_data)
    );

endmodule

// ----- sim/demand_paged_address_translator_tb.sv -----
// testbench for demand_paged_address_translator: directed table, random xlate/load/nop traffic
// checks every output transaction against a built-in page table and swap-in predictor
// depends on dpat_pkg and the demand_paged_address_translator rtl
`timescale 1ns / 100ps

module demand_paged_address_translator_tb;
    import dpat_pkg::*;

    localparam int MAIN_SIZE        = 65536;
    localparam int DISK_SIZE        = 4096;
    localparam int RAND_ITEMS       = 1400;
    localparam int MAX_FILLED_PAGES = 2;
    localparam int N_DIR            = 21;

    typedef struct packed {
        logic        fault;
        logic [7:0]  frame;
        logic [15:0] phys;
        logic [7:0]  data;
    } t_xlate_result;

    typedef struct packed {
        logic [1:0]    mode;
        logic [15:0]   addr;
        logic [7:0]    wdata;
        logic          typed;
        t_xlate_result res;
    } t_vector;

    typedef enum {GAP_MAIN, GAP_DISK, GAP_REMAP} t_gap;

    localparam t_xlate_result ZERO_RES = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_fault;
    logic [7:0]  o_frame;
    logic [15:0] o_phys_address;
    logic [7:0]  o_data;

    logic [7:0]    main_img [MAIN_SIZE];
    bit            main_known [MAIN_SIZE];
    logic [7:0]    disk_img [DISK_SIZE];
    bit            disk_known [DISK_SIZE];
    bit            page_used [DISK_SIZE / PAGE_BYTES];
    int            used_pages [$];
    t_xlate_result xlate_results [$];
    t_xlate_result head_res;
    int            sent_count = 0;
    int            err_count = 0;
    bit            calm = 1'b0;

    t_vector dir_rows [N_DIR] = '{
        '{MODE_NOP,       16'h0000, 8'h00, 1'b1, ZERO_RES},
        '{MODE_NOP,       16'hFFFF, 8'hFF, 1'b1, ZERO_RES},
        '{MODE_LOAD_MAIN, 16'hFFFF, 8'hFF, 1'b1, ZERO_RES},
        '{MODE_LOAD_MAIN, 16'h0000, 8'h00, 1'b1, ZERO_RES},
        '{MODE_LOAD_MAIN, 16'h0100, 8'h01, 1'b1, ZERO_RES},
        '{MODE_LOAD_MAIN, 16'h00FF, 8'hFF, 1'b1, ZERO_RES},
        '{MODE_LOAD_MAIN, 16'h01FF, 8'h80, 1'b1, ZERO_RES},
        '{MODE_LOAD_DISK, 16'hFFFF, 8'hFF, 1'b1, ZERO_RES},
        '{MODE_LOAD_DISK, 16'h0000, 8'h00, 1'b1, ZERO_RES},
        '{MODE_XLATE,     16'h0000, 8'h00, 1'b1, '{1'b0, 8'h00, 16'h0000, 8'h00}},
        '{MODE_XLATE,     16'h00FF, 8'hFF, 1'b1, '{1'b0, 8'h00, 16'h00FF, 8'hFF}},
        '{MODE_XLATE,     16'hFFFF, 8'h00, 1'b1, '{1'b0, 8'hFF, 16'hFFFF, 8'hFF}},
        '{MODE_LOAD_MAIN, 16'h0001, 8'h7F, 1'b1, ZERO_RES},
        '{MODE_LOAD_MAIN, 16'h0101, 8'hFE, 1'b1, ZERO_RES},
        '{MODE_LOAD_MAIN, 16'h7F80, 8'h20, 1'b1, ZERO_RES},
        '{MODE_XLATE,     16'h0180, 8'hAA, 1'b0, ZERO_RES},
        '{MODE_NOP,       16'h5555, 8'hAA, 1'b1, ZERO_RES},
        '{MODE_LOAD_DISK, 16'hAAAA, 8'h55, 1'b1, ZERO_RES},
        '{MODE_LOAD_MAIN, 16'hAAAA, 8'h55, 1'b1, ZERO_RES},
        '{MODE_XLATE,     16'h0001, 8'h55, 1'b0, ZERO_RES},
        '{MODE_LOAD_MAIN, 16'h0100, 8'h00, 1'b1, ZERO_RES}
    };

    demand_paged_address_translator #(
        .MAIN_BYTES(MAIN_SIZE),
        .DISK_BYTES(DISK_SIZE)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_fault        (o_fault),
        .o_frame        (o_frame),
        .o_phys_address (o_phys_address),
        .o_data         (o_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void main_write(int a, logic [7:0] v);
        main_img[a % MAIN_SIZE]   = v;
        main_known[a % MAIN_SIZE] = 1'b1;
    endfunction

    function automatic t_xlate_result translate_step(logic [1:0] mode, logic [15:0] addr,
                                                     logic [7:0] wdata);
        t_xlate_result r;
        int            pfn;
        int            slot;
        r = '0;
        case (mode)
            MODE_XLATE: begin
                pfn     = main_img[addr[15:8]];
                r.frame = pfn[7:0];
                if (main_img[{8'h01, addr[15:8]}] == 8'h00) begin
                    slot = FIRST_DATA_FRAME;
                    for (int f = FIRST_DATA_FRAME; f * PAGE_BYTES + PAGE_BYTES <= MAIN_SIZE;
                         f++) begin
                        if (main_img[f * PAGE_BYTES] == FREE_MARK) begin
                            slot = f;
                            break;
                        end
                    end
                    for (int k = 0; k < PAGE_BYTES; k++)
                        main_write(slot * PAGE_BYTES + k,
                                   disk_img[(pfn * PAGE_BYTES + k) % DISK_SIZE]);
                    main_write(addr[15:8], slot[7:0]);
                    main_write({8'h01, addr[15:8]}, PRESENT_SET);
                    r.fault = 1'b1;
                end else begin
                    r.phys = {pfn[7:0], addr[7:0]};
                    r.data = main_img[r.phys];
                end
            end
            MODE_LOAD_MAIN: main_write(addr, wdata);
            MODE_LOAD_DISK: begin
                disk_img[addr % DISK_SIZE]   = wdata;
                disk_known[addr % DISK_SIZE] = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // finds the first store byte a translation would read before it is written
    function automatic bit find_gap(logic [15:0] addr, output t_gap kind, output int gap_addr);
        int pfn;
        int idx;
        kind     = GAP_MAIN;
        gap_addr = 0;
        if (!main_known[addr[15:8]]) begin
            gap_addr = addr[15:8];
            return 1'b1;
        end
        if (!main_known[{8'h01, addr[15:8]}]) begin
            gap_addr = {8'h01, addr[15:8]};
            return 1'b1;
        end
        pfn = main_img[addr[15:8]];
        if (main_img[{8'h01, addr[15:8]}] != 8'h00) begin
            gap_addr = {pfn[7:0], addr[7:0]};
            return !main_known[gap_addr];
        end
        for (int f = FIRST_DATA_FRAME; f * PAGE_BYTES + PAGE_BYTES <= MAIN_SIZE; f++) begin
            if (!main_known[f * PAGE_BYTES]) begin
                gap_addr = f * PAGE_BYTES;
                return 1'b1;
            end
            if (main_img[f * PAGE_BYTES] == FREE_MARK)
                break;
        end
        for (int k = 0; k < PAGE_BYTES; k++) begin
            idx = (pfn * PAGE_BYTES + k) % DISK_SIZE;
            if (!disk_known[idx]) begin
                if (!page_used[idx / PAGE_BYTES] && used_pages.size() >= MAX_FILLED_PAGES) begin
                    kind     = GAP_REMAP;
                    gap_addr = addr[15:8];
                end else begin
                    kind     = GAP_DISK;
                    gap_addr = idx;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_pfn(bit filled_only);
        if (used_pages.size() != 0 && (filled_only || $urandom_range(0, 9) < 7))
            return {4'($urandom_range(0, 15)),
                    4'(used_pages[$urandom_range(0, used_pages.size() - 1)])};
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_main_data(logic [15:0] a);
        if (a < 16'h0100)
            return pick_pfn(1'b0);
        if (a < 16'h0200) begin
            case ($urandom_range(0, 3))
                0, 1:    return 8'h00;
                2:       return PRESENT_SET;
                default: return 8'($urandom_range(1, 255));
            endcase
        end
        if (a[7:0] == 8'h00 && $urandom_range(0, 2) == 0)
            return FREE_MARK;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_disk_data();
        return ($urandom_range(0, 3) == 0) ? FREE_MARK : 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [15:0] addr,
                             input logic [7:0] wdata, input bit typed,
                             input t_xlate_result typed_res);
        t_xlate_result res;
        if (!calm) begin
            while ($urandom_range(0, 99) < 14) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_address    <= addr;
        i_write_data <= wdata;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        res = translate_step(mode, addr, wdata);
        xlate_results.push_back(typed ? typed_res : res);
        sent_count++;
    endtask

    // programs whatever the translation would read unwritten, then sends it
    task automatic xlate_seq(input logic [15:0] addr);
        t_gap kind;
        int   gap_addr;
        while (find_gap(addr, kind, gap_addr)) begin
            case (kind)
                GAP_MAIN:
                    send_item(MODE_LOAD_MAIN, 16'(gap_addr), pick_main_data(16'(gap_addr)),
                              1'b0, ZERO_RES);
                GAP_DISK: begin
                    if (!page_used[gap_addr / PAGE_BYTES]) begin
                        page_used[gap_addr / PAGE_BYTES] = 1'b1;
                        used_pages.push_back(gap_addr / PAGE_BYTES);
                    end
                    send_item(MODE_LOAD_DISK, {4'($urandom_range(0, 15)), 12'(gap_addr)},
                              pick_disk_data(), 1'b0, ZERO_RES);
                end
                default:
                    send_item(MODE_LOAD_MAIN, 16'(gap_addr), pick_pfn(1'b1), 1'b0, ZERO_RES);
            endcase
        end
        send_item(MODE_XLATE, addr, 8'($urandom_range(0, 255)), 1'b0, ZERO_RES);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk)
        i_out_stall <= !calm && ($urandom_range(0, 99) < 14);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (xlate_results.size() == 0) begin
                $display("%0t unexpected transaction fault %b frame %h phys %h data %h",
                         $time, o_fault, o_frame, o_phys_address, o_data);
                err_count++;
            end else begin
                head_res = xlate_results.pop_front();
                check_field("fault", 16'(head_res.fault), 16'(o_fault));
                check_field("frame", 16'(head_res.frame), 16'(o_frame));
                check_field("phys_address", head_res.phys, o_phys_address);
                check_field("data", 16'(head_res.data), 16'(o_data));
            end
        end
    end

    initial begin : stim
        int          pick;
        logic [7:0]  vpn;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_mode       = MODE_NOP;
        i_address    = 16'h0000;
        i_write_data = 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++)
            send_item(dir_rows[k].mode, dir_rows[k].addr, dir_rows[k].wdata,
                      dir_rows[k].typed, dir_rows[k].res);

        while (sent_count < N_DIR + RAND_ITEMS) begin
            calm = (sent_count >= N_DIR + 500) && (sent_count < N_DIR + 800);
            pick = $urandom_range(0, 99);
            vpn  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15))
                                               : 8'($urandom_range(0, 255));
            if (pick < 55) begin
                xlate_seq({vpn, 8'($urandom_range(0, 255))});
            end else if (pick < 70) begin
                case ($urandom_range(0, 3))
                    0, 1: begin
                        vpn = 8'($urandom_range(0, 255));
                        send_item(MODE_LOAD_MAIN, {7'd0, 1'($urandom_range(0, 1)), vpn},
                                  pick_main_data({7'd0, 1'b1, vpn}), 1'b0, ZERO_RES);
                    end
                    2:
                        send_item(MODE_LOAD_MAIN, {8'($urandom_range(2, 255)), 8'h00},
                                  pick_main_data(16'h0200), 1'b0, ZERO_RES);
                    default:
                        send_item(MODE_LOAD_MAIN, 16'($urandom_range(0, 65535)),
                                  8'($urandom_range(0, 255)), 1'b0, ZERO_RES);
                endcase
            end else if (pick < 80) begin
                send_item(MODE_LOAD_DISK, 16'($urandom_range(0, 65535)), pick_disk_data(),
                          1'b0, ZERO_RES);
            end else if (pick < 87) begin
                send_item(MODE_NOP, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                          1'b0, ZERO_RES);
            end else begin
                // drop a page so the next translation of it faults
                send_item(MODE_LOAD_MAIN, {8'h01, vpn}, 8'h00, 1'b0, ZERO_RES);
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (xlate_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- demand_paged_address_translator.f -----
hw/rtl/dpat_pkg.sv
hw/rtl/dpat_datapath.sv
hw/rtl/dpat_ctrl.sv
hw/rtl/demand_paged_address_translator.sv
sim/demand_paged_address_translator_tb.sv
